// File: design/tss_pkg.sv
package tss_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 240;

    localparam int COORD_W  = 11;
    localparam int ROW_W    = 10;
    localparam int COLOUR_W = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int QUOT_W   = COORD_W;
    localparam int DIV_W    = COORD_W;
    localparam int MAG_W    = QUOT_W + DIV_W;
    localparam int HIT_W    = DIFF_W + 1;
    localparam int NUM_LANES  = 2;
    localparam int DIV_STAGES = QUOT_W;

    localparam logic [ROW_W:0]            ROW_LIMIT = (ROW_W + 1)'(SCREEN_HEIGHT);
    localparam logic signed [HIT_W-1:0]   X_LIMIT   = HIT_W'(SCREEN_WIDTH);
    localparam logic signed [HIT_W-1:0]   X_MAX     = HIT_W'(SCREEN_WIDTH - 1);

    typedef enum logic [1:0] {
        EDGE_AB = 2'd0,
        EDGE_BC = 2'd1,
        EDGE_CA = 2'd2
    } edge_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [HIT_W-1:0]   hit_t;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COLOUR_W-1:0] colour;
        logic                ok;
    } hdr_t;

    typedef struct packed {
        coord_t x0;
        diff_t  rdy;
        diff_t  dx;
        diff_t  dy;
    } prep_lane_t;

    typedef struct packed {
        coord_t                   x0;
        logic signed [PROD_W-1:0] num;
        diff_t                    dy;
    } mul_lane_t;

    typedef struct packed {
        coord_t            x0;
        logic              neg;
        logic [DIV_W-1:0]  dsr;
        logic [DIV_W-1:0]  rem;
        logic [QUOT_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        hdr_t                        hdr;
        prep_lane_t [NUM_LANES-1:0]  lane;
    } prep_item_t;

    typedef struct packed {
        hdr_t                       hdr;
        mul_lane_t [NUM_LANES-1:0]  lane;
    } mul_item_t;

    typedef struct packed {
        hdr_t                       hdr;
        div_lane_t [NUM_LANES-1:0]  lane;
    } div_item_t;

    typedef struct packed {
        hdr_t                  hdr;
        hit_t [NUM_LANES-1:0]  hit;
    } hit_item_t;

endpackage

// File: design/triangle_scanline_span.sv
// Rasterizes one screen row of a filled triangle per word: each accepted word
// gives exactly one result word, in order, with the clipped span of that row or
// a cleared span marked not valid. The block takes a new word every cycle while
// the result side is not stalling and holds no state between words. The word
// passes through edge selection, multiplication and sign handling, the pipelined
// restoring divider (one quotient bit per stage for the two intercepts), and
// then the intercept add and the ordering and clipping, each step registered.
// Back-pressure on the result side stalls the pipeline stage by stage, so empty
// stages still fill while the output waits.
module triangle_scanline_span
    import tss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  coord_t              s_ax_pos,
    input  coord_t              s_ay_pos,
    input  coord_t              s_bx_pos,
    input  coord_t              s_by_pos,
    input  coord_t              s_cx_pos,
    input  coord_t              s_cy_pos,
    input  logic [ROW_W-1:0]    s_scan_row,
    input  logic [COLOUR_W-1:0] s_fill_colour,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_span_valid,
    output logic [ROW_W-1:0]    m_span_row,
    output logic [ROW_W-1:0]    m_span_first,
    output logic [ROW_W-1:0]    m_span_final,
    output logic [COLOUR_W-1:0] m_span_colour
);

    logic      div_valid [0:DIV_STAGES];
    logic      div_ready [0:DIV_STAGES];
    div_item_t div_data  [0:DIV_STAGES];

    tss_edge_prep u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .ax_pos      (s_ax_pos),
        .ay_pos      (s_ay_pos),
        .bx_pos      (s_bx_pos),
        .by_pos      (s_by_pos),
        .cx_pos      (s_cx_pos),
        .cy_pos      (s_cy_pos),
        .scan_row    (s_scan_row),
        .fill_colour (s_fill_colour),
        .out_valid   (div_valid[0]),
        .out_ready   (div_ready[0]),
        .out_data    (div_data[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        tss_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    tss_span_clip u_clip (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (div_valid[DIV_STAGES]),
        .in_ready    (div_ready[DIV_STAGES]),
        .in_data     (div_data[DIV_STAGES]),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .span_valid  (m_span_valid),
        .span_row    (m_span_row),
        .span_first  (m_span_first),
        .span_final  (m_span_final),
        .span_colour (m_span_colour)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_span_valid |-> m_span_first <= m_span_final)
        else $error("Span ends are out of order.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_span_valid |-> int'(m_span_final) < SCREEN_WIDTH)
        else $error("Span runs past the screen edge.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_span_valid |-> int'(m_span_row) < SCREEN_HEIGHT)
        else $error("Span reported for a row below the screen.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_span_valid |->
            (m_span_first == '0) && (m_span_final == '0) && (m_span_colour == '0))
        else $error("Not-valid span carries nonzero fields.");

endmodule

// File: design/tss_edge_prep.sv
module tss_edge_prep
    import tss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  coord_t              ax_pos,
    input  coord_t              ay_pos,
    input  coord_t              bx_pos,
    input  coord_t              by_pos,
    input  coord_t              cx_pos,
    input  coord_t              cy_pos,
    input  logic [ROW_W-1:0]    scan_row,
    input  logic [COLOUR_W-1:0] fill_colour,
    output logic                out_valid,
    input  logic                out_ready,
    output div_item_t           out_data
);

    logic       pipe_valid_reg [0:2];
    logic       stage_ready    [0:2];
    prep_item_t prep_reg, prep_next;
    mul_item_t  mul_reg, mul_next;
    div_item_t  div_reg, div_next;

    coord_t vx [0:2];
    coord_t vy [0:2];
    logic   crossing [0:2];
    diff_t  row_s;
    edge_t  sel0, sel1;

    function automatic logic crosses(input coord_t y0, input coord_t y1, input diff_t row);
        diff_t s0, s1;
        s0 = DIFF_W'(y0);
        s1 = DIFF_W'(y1);
        return ((s0 <= row) && (s1 > row)) || ((s1 <= row) && (s0 > row));
    endfunction

    function automatic prep_lane_t make_lane(input coord_t x0, input coord_t y0,
                                             input coord_t x1, input coord_t y1,
                                             input diff_t row);
        prep_lane_t l;
        l.x0  = x0;
        l.rdy = row - DIFF_W'(y0);
        l.dx  = DIFF_W'(x1) - DIFF_W'(x0);
        l.dy  = DIFF_W'(y1) - DIFF_W'(y0);
        return l;
    endfunction

    function automatic prep_lane_t edge_lane(input edge_t e, input coord_t px [0:2],
                                             input coord_t py [0:2], input diff_t row);
        prep_lane_t l;
        unique case (e)
            EDGE_AB: l = make_lane(px[0], py[0], px[1], py[1], row);
            EDGE_BC: l = make_lane(px[1], py[1], px[2], py[2], row);
            EDGE_CA: l = make_lane(px[2], py[2], px[0], py[0], row);
            default: l = make_lane(px[2], py[2], px[0], py[0], row);
        endcase
        return l;
    endfunction

    assign stage_ready[2] = !pipe_valid_reg[2] || out_ready;
    assign stage_ready[1] = !pipe_valid_reg[1] || stage_ready[2];
    assign stage_ready[0] = !pipe_valid_reg[0] || stage_ready[1];
    assign in_ready       = stage_ready[0];
    assign out_valid      = pipe_valid_reg[2];
    assign out_data       = div_reg;

    always_comb begin
        vx[0] = ax_pos;
        vx[1] = bx_pos;
        vx[2] = cx_pos;
        vy[0] = ay_pos;
        vy[1] = by_pos;
        vy[2] = cy_pos;
        row_s = $signed({2'b00, scan_row});
        crossing[0] = crosses(ay_pos, by_pos, row_s);
        crossing[1] = crosses(by_pos, cy_pos, row_s);
        crossing[2] = crosses(cy_pos, ay_pos, row_s);

        priority if (crossing[0]) begin
            sel0 = EDGE_AB;
        end else if (crossing[1]) begin
            sel0 = EDGE_BC;
        end else begin
            sel0 = EDGE_CA;
        end
        sel1 = (crossing[0] && crossing[1]) ? EDGE_BC : EDGE_CA;

        prep_next.hdr.row    = scan_row;
        prep_next.hdr.colour = fill_colour;
        prep_next.hdr.ok     = ({1'b0, scan_row} < ROW_LIMIT) &&
                               ((crossing[0] && crossing[1]) ||
                                (crossing[0] && crossing[2]) ||
                                (crossing[1] && crossing[2]));
        prep_next.lane[0]    = edge_lane(sel0, vx, vy, row_s);
        prep_next.lane[1]    = edge_lane(sel1, vx, vy, row_s);
    end

    always_comb begin
        mul_next.hdr = prep_reg.hdr;
        for (int i = 0; i < NUM_LANES; i++) begin
            mul_next.lane[i].x0  = prep_reg.lane[i].x0;
            mul_next.lane[i].num = PROD_W'(prep_reg.lane[i].rdy) *
                                   PROD_W'(prep_reg.lane[i].dx);
            mul_next.lane[i].dy  = prep_reg.lane[i].dy;
        end
    end

    always_comb begin
        logic [PROD_W-1:0] num_mag;
        logic [DIFF_W-1:0] dy_mag;
        div_next.hdr = mul_reg.hdr;
        for (int i = 0; i < NUM_LANES; i++) begin
            num_mag = mul_reg.lane[i].num[PROD_W-1] ? PROD_W'(-mul_reg.lane[i].num)
                                                    : PROD_W'(mul_reg.lane[i].num);
            dy_mag  = mul_reg.lane[i].dy[DIFF_W-1] ? DIFF_W'(-mul_reg.lane[i].dy)
                                                   : DIFF_W'(mul_reg.lane[i].dy);
            div_next.lane[i].x0  = mul_reg.lane[i].x0;
            div_next.lane[i].neg = mul_reg.lane[i].num[PROD_W-1] ^
                                   mul_reg.lane[i].dy[DIFF_W-1];
            div_next.lane[i].dsr = dy_mag[DIV_W-1:0];
            div_next.lane[i].rem = num_mag[MAG_W-1:QUOT_W];
            div_next.lane[i].quo = num_mag[QUOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_valid_reg[0] <= 1'b0;
            pipe_valid_reg[1] <= 1'b0;
            pipe_valid_reg[2] <= 1'b0;
        end else begin
            if (stage_ready[0]) begin
                pipe_valid_reg[0] <= in_valid;
            end
            if (stage_ready[1]) begin
                pipe_valid_reg[1] <= pipe_valid_reg[0];
            end
            if (stage_ready[2]) begin
                pipe_valid_reg[2] <= pipe_valid_reg[1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            prep_reg <= prep_next;
        end
        if (stage_ready[1]) begin
            mul_reg <= mul_next;
        end
        if (stage_ready[2]) begin
            div_reg <= div_next;
        end
    end

endmodule

// File: design/tss_div_step.sv
module tss_div_step
    import tss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_data
);

    logic      valid_reg;
    div_item_t data_reg, data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        logic           ge;
        data_next = in_data;
        for (int i = 0; i < NUM_LANES; i++) begin
            trial = {in_data.lane[i].rem, in_data.lane[i].quo[QUOT_W-1]};
            diff  = trial - {1'b0, in_data.lane[i].dsr};
            ge    = trial >= {1'b0, in_data.lane[i].dsr};
            data_next.lane[i].rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            data_next.lane[i].quo = {in_data.lane[i].quo[QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/tss_span_clip.sv
module tss_span_clip
    import tss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  div_item_t           in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                span_valid,
    output logic [ROW_W-1:0]    span_row,
    output logic [ROW_W-1:0]    span_first,
    output logic [ROW_W-1:0]    span_final,
    output logic [COLOUR_W-1:0] span_colour
);

    logic      hit_valid_reg, out_valid_reg;
    logic      hit_ready, out_stage_ready;
    hit_item_t hit_reg, hit_next;

    logic                span_valid_reg, span_valid_next;
    logic [ROW_W-1:0]    span_row_reg, span_row_next;
    logic [ROW_W-1:0]    span_first_reg, span_first_next;
    logic [ROW_W-1:0]    span_final_reg, span_final_next;
    logic [COLOUR_W-1:0] span_colour_reg, span_colour_next;

    hit_t lo, hi, lo_clip, hi_clip;

    assign out_stage_ready = !out_valid_reg || out_ready;
    assign hit_ready       = !hit_valid_reg || out_stage_ready;
    assign in_ready        = hit_ready;
    assign out_valid       = out_valid_reg;
    assign span_valid      = span_valid_reg;
    assign span_row        = span_row_reg;
    assign span_first      = span_first_reg;
    assign span_final      = span_final_reg;
    assign span_colour     = span_colour_reg;

    always_comb begin
        logic signed [DIFF_W-1:0] q;
        hit_next.hdr = in_data.hdr;
        for (int i = 0; i < NUM_LANES; i++) begin
            q = $signed({1'b0, in_data.lane[i].quo});
            if (in_data.lane[i].neg) begin
                q = -q;
            end
            hit_next.hit[i] = HIT_W'(in_data.lane[i].x0) + HIT_W'(q);
        end
    end

    always_comb begin
        lo      = (hit_reg.hit[0] < hit_reg.hit[1]) ? hit_reg.hit[0] : hit_reg.hit[1];
        hi      = (hit_reg.hit[0] < hit_reg.hit[1]) ? hit_reg.hit[1] : hit_reg.hit[0];
        lo_clip = lo[HIT_W-1] ? '0 : lo;
        hi_clip = (hi > X_MAX) ? X_MAX : hi;

        span_row_next = hit_reg.hdr.row;
        if (hit_reg.hdr.ok && !hi[HIT_W-1] && (lo < X_LIMIT)) begin
            span_valid_next  = 1'b1;
            span_first_next  = lo_clip[ROW_W-1:0];
            span_final_next  = hi_clip[ROW_W-1:0];
            span_colour_next = hit_reg.hdr.colour;
        end else begin
            span_valid_next  = 1'b0;
            span_first_next  = '0;
            span_final_next  = '0;
            span_colour_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (hit_ready) begin
                hit_valid_reg <= in_valid;
            end
            if (out_stage_ready) begin
                out_valid_reg <= hit_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hit_ready) begin
            hit_reg <= hit_next;
        end
        if (out_stage_ready) begin
            span_valid_reg  <= span_valid_next;
            span_row_reg    <= span_row_next;
            span_first_reg  <= span_first_next;
            span_final_reg  <= span_final_next;
            span_colour_reg <= span_colour_next;
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tss_pkg::*;

    typedef struct {
        coord_t              ax;
        coord_t              ay;
        coord_t              bx;
        coord_t              by;
        coord_t              cx;
        coord_t              cy;
        logic [ROW_W-1:0]    row;
        logic [COLOUR_W-1:0] colour;
    } tri_row_t;

    typedef struct {
        logic                valid;
        logic [ROW_W-1:0]    row;
        logic [ROW_W-1:0]    first_px;
        logic [ROW_W-1:0]    last_px;
        logic [COLOUR_W-1:0] colour;
    } span_t;

    function automatic span_t predict_span(tri_row_t r);
        span_t s;
        int vx[3];
        int vy[3];
        int hit[2];
        int n_hits;
        int row;
        int nx;
        int lo;
        int hi;
        row = int'(r.row);
        vx[0] = r.ax;
        vy[0] = r.ay;
        vx[1] = r.bx;
        vy[1] = r.by;
        vx[2] = r.cx;
        vy[2] = r.cy;
        n_hits = 0;
        s.valid = 1'b0;
        s.row = r.row;
        s.first_px = '0;
        s.last_px = '0;
        s.colour = '0;
        if (row >= SCREEN_HEIGHT) begin
            return s;
        end
        for (int e = EDGE_AB; e <= EDGE_CA; e++) begin
            nx = (e == EDGE_CA) ? EDGE_AB : e + 1;
            if (n_hits < 2 && ((vy[e] <= row && vy[nx] > row) || (vy[nx] <= row && vy[e] > row)))
            begin
                hit[n_hits] = vx[e] + ((row - vy[e]) * (vx[nx] - vx[e])) / (vy[nx] - vy[e]);
                n_hits++;
            end
        end
        if (n_hits < 2) begin
            return s;
        end
        lo = (hit[0] < hit[1]) ? hit[0] : hit[1];
        hi = (hit[0] < hit[1]) ? hit[1] : hit[0];
        if (hi < 0 || lo >= SCREEN_WIDTH) begin
            return s;
        end
        if (lo < 0) begin
            lo = 0;
        end
        if (hi > SCREEN_WIDTH - 1) begin
            hi = SCREEN_WIDTH - 1;
        end
        s.valid = 1'b1;
        s.first_px = lo[ROW_W-1:0];
        s.last_px = hi[ROW_W-1:0];
        s.colour = r.colour;
        return s;
    endfunction

    class span_scoreboard;
        span_t expected_spans[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t ns: span mismatch: %s", $time, msg);
        endtask

        function void note_row(tri_row_t r);
            expected_spans.push_back(predict_span(r));
        endfunction

        task check_span(span_t got);
            span_t want;
            if (expected_spans.size() == 0) begin
                report_mismatch("result word with no row outstanding");
                return;
            end
            want = expected_spans.pop_front();
            if (got.valid !== want.valid) begin
                report_mismatch($sformatf("row %0d valid %0b, want %0b",
                                          want.row, got.valid, want.valid));
            end
            if (got.row !== want.row) begin
                report_mismatch($sformatf("row %0d, want %0d", got.row, want.row));
            end
            if (got.first_px !== want.first_px) begin
                report_mismatch($sformatf("row %0d first %0d, want %0d",
                                          want.row, got.first_px, want.first_px));
            end
            if (got.last_px !== want.last_px) begin
                report_mismatch($sformatf("row %0d last %0d, want %0d",
                                          want.row, got.last_px, want.last_px));
            end
            if (got.colour !== want.colour) begin
                report_mismatch($sformatf("row %0d colour %h, want %h",
                                          want.row, got.colour, want.colour));
            end
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    coord_t              s_ax_pos = '0;
    coord_t              s_ay_pos = '0;
    coord_t              s_bx_pos = '0;
    coord_t              s_by_pos = '0;
    coord_t              s_cx_pos = '0;
    coord_t              s_cy_pos = '0;
    logic [ROW_W-1:0]    s_scan_row = '0;
    logic [COLOUR_W-1:0] s_fill_colour = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_span_valid;
    logic [ROW_W-1:0]    m_span_row;
    logic [ROW_W-1:0]    m_span_first;
    logic [ROW_W-1:0]    m_span_final;
    logic [COLOUR_W-1:0] m_span_colour;

    int send_gap_pct = 10;
    int recv_stall_pct = 10;

    span_scoreboard spans = new();

    triangle_scanline_span DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ax_pos      (s_ax_pos),
        .s_ay_pos      (s_ay_pos),
        .s_bx_pos      (s_bx_pos),
        .s_by_pos      (s_by_pos),
        .s_cx_pos      (s_cx_pos),
        .s_cy_pos      (s_cy_pos),
        .s_scan_row    (s_scan_row),
        .s_fill_colour (s_fill_colour),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_span_valid  (m_span_valid),
        .m_span_row    (m_span_row),
        .m_span_first  (m_span_first),
        .m_span_final  (m_span_final),
        .m_span_colour (m_span_colour)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        span_t got;
        if (aresetn && m_valid && m_ready) begin
            got.valid = m_span_valid;
            got.row = m_span_row;
            got.first_px = m_span_first;
            got.last_px = m_span_final;
            got.colour = m_span_colour;
            spans.check_span(got);
        end
    end

    function automatic tri_row_t make_row(int ax, int ay, int bx, int by, int cx, int cy,
                                          int row, int colour);
        tri_row_t r;
        r.ax = coord_t'(ax);
        r.ay = coord_t'(ay);
        r.bx = coord_t'(bx);
        r.by = coord_t'(by);
        r.cx = coord_t'(cx);
        r.cy = coord_t'(cy);
        r.row = row[ROW_W-1:0];
        r.colour = colour[COLOUR_W-1:0];
        return r;
    endfunction

    function automatic int rand_between(int lo_v, int hi_v);
        return lo_v + int'($urandom_range(hi_v - lo_v));
    endfunction

    function automatic tri_row_t random_row();
        tri_row_t r;
        int pick;
        int bx;
        int by;
        int ymin;
        int ymax;
        int lo_r;
        int hi_r;
        pick = $urandom_range(99);
        if (pick < 70) begin
            r = make_row(rand_between(-120, 360), rand_between(-60, 300),
                         rand_between(-120, 360), rand_between(-60, 300),
                         rand_between(-120, 360), rand_between(-60, 300), 0, 0);
        end else if (pick < 85) begin
            bx = rand_between(-40, 280);
            by = rand_between(-20, 260);
            r = make_row(bx, by, bx + rand_between(-20, 20), by + rand_between(-20, 20),
                         bx + rand_between(-20, 20), by + rand_between(-20, 20), 0, 0);
        end else begin
            r = make_row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0);
        end
        ymin = r.ay;
        ymax = r.ay;
        if (r.by < ymin) ymin = r.by;
        if (r.cy < ymin) ymin = r.cy;
        if (r.by > ymax) ymax = r.by;
        if (r.cy > ymax) ymax = r.cy;
        lo_r = (ymin < 0) ? 0 : ymin;
        hi_r = (ymax > SCREEN_HEIGHT - 1) ? SCREEN_HEIGHT - 1 : ymax;
        pick = $urandom_range(99);
        if (pick < 85 && lo_r <= hi_r) begin
            r.row = ROW_W'($urandom_range(hi_r, lo_r));
        end else if (pick < 93) begin
            r.row = ROW_W'($urandom);
        end else begin
            r.row = ROW_W'($urandom_range(SCREEN_HEIGHT - 1));
        end
        r.colour = COLOUR_W'($urandom);
        return r;
    endfunction

    task automatic send_row(tri_row_t r);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_ax_pos = r.ax;
        s_ay_pos = r.ay;
        s_bx_pos = r.bx;
        s_by_pos = r.by;
        s_cx_pos = r.cx;
        s_cy_pos = r.cy;
        s_scan_row = r.row;
        s_fill_colour = r.colour;
        s_valid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        spans.note_row(r);
        @(negedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Rows on the top vertex, the middle vertex, the bottom vertex and between.
        send_row(make_row(20, 10, 200, 50, 100, 220, 10, 16'hF800));
        send_row(make_row(20, 10, 200, 50, 100, 220, 50, 16'h07E0));
        send_row(make_row(20, 10, 200, 50, 100, 220, 220, 16'h001F));
        send_row(make_row(20, 10, 200, 50, 100, 220, 100, 16'h0000));
        // A triangle at the coordinate extremes, clipped on both sides.
        send_row(make_row(-1024, -1024, 1023, -1024, 0, 1023, 0, 16'hFFFF));
        send_row(make_row(-1024, -1024, 1023, -1024, 0, 1023, 239, 16'hAAAA));
        send_row(make_row(-1024, -1024, 1023, -1024, 0, 1023, 240, 16'h5555));
        send_row(make_row(-1024, -1024, 1023, -1024, 0, 1023, 1023, 16'hFFFF));
        send_row(make_row(1023, 1023, -1024, 1023, 0, -1024, 100, 16'h1234));
        // Flat and point triangles give no span; two equal vertices still can give one.
        send_row(make_row(0, 100, 100, 100, 200, 100, 100, 16'h4321));
        send_row(make_row(50, 50, 50, 50, 50, 50, 50, 16'h0F0F));
        send_row(make_row(30, 40, 30, 40, 90, 120, 60, 16'hF0F0));
        // Spans wholly left, wholly right, touching the right edge, and just off the left edge.
        send_row(make_row(-300, 0, -10, 200, -150, 100, 100, 16'h8001));
        send_row(make_row(240, 0, 500, 200, 300, 150, 100, 16'h8002));
        send_row(make_row(239, 0, 239, 200, 400, 100, 50, 16'h8003));
        send_row(make_row(-1, 0, -1, 200, -400, 100, 50, 16'h8004));
        // Negative intercepts that truncate toward zero.
        send_row(make_row(0, 0, -10, 3, 100, 3, 1, 16'h7777));
        send_row(make_row(5, 0, -20, 7, 3, 9, 4, 16'h3C3C));
        // Both windings, so either intercept can be the left one.
        send_row(make_row(200, 0, 0, 200, 220, 200, 100, 16'hC3C3));
        send_row(make_row(200, 0, 220, 200, 0, 200, 100, 16'h0001));
        send_row(make_row(120, -500, 900, 600, -700, 400, 0, 16'h8000));

        for (int i = 0; i < 1450; i++) begin
            send_gap_pct = (i >= 500 && i < 800) ? 0 : 10;
            recv_stall_pct = send_gap_pct;
            send_row(random_row());
        end
        s_valid = 1'b0;

        while (spans.expected_spans.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
        if (spans.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/tss_pkg.sv
design/tss_edge_prep.sv
design/tss_div_step.sv
design/tss_span_clip.sv
design/triangle_scanline_span.sv
tb/sv/testbench.sv
